/* hdl/cac_pkg.sv */
// ----------------------------------------------------------------------------
// cac_pkg: shared types and constants of the consecutive access counter
// Table geometry, configuration register indexes and the command and status
// words passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cac_pkg;

  // Number of distinct object indexes, and lanes per warp.
  localparam int OBJECTS = 256;
  localparam int LANES   = 32;

  // Derived widths.
  localparam int IDX_W     = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
  localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int TAB_DEPTH = OBJECTS * OBJECTS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  // Field widths fixed by the interface.
  localparam int ADDR_W   = 64;
  localparam int ID_W     = 16;
  localparam int WARP_W   = 5;
  localparam int LANE_IN_W = 5;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 32;
  localparam int OSL2_W   = 3;
  localparam int KEY_W    = 3 * ID_W + WARP_W;

  // Configuration port.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 64;
  localparam logic [CFG_AW-1:0] CFG_TARGET_LAUNCH    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_REGION_START     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_OBJECT_SIZE_LOG2 = 2'd2;

  // Reset value of the object size register: four byte objects.
  localparam logic [OSL2_W-1:0] OSL2_RESET = 3'd2;
  // Largest shift the index calculation applies.
  localparam logic [OSL2_W-1:0] OSL2_MAX   = 3'd6;

  // Request types.
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;   // clear one table entry
    logic load;  // capture an input word
    logic calc;  // key compare, index and history update
    logic rd;    // read the count table
    logic upd;   // write back and register the result
  } cac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last entry
  } cac_sts_t;

endpackage

/* hdl/cac_ctrl.sv */
// ----------------------------------------------------------------------------
// cac_ctrl: sequencer of the consecutive access counter
// Runs the table clearing pass after reset, then steps each accepted word
// through index calculation, count read and write back.
// ----------------------------------------------------------------------------
module cac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cac_pkg::cac_sts_t sts_i,
  output cac_pkg::cac_cmd_t cmd_o,
  output logic              busy,
  output logic              done_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_READ,
    S_UPDATE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // State, busy flag and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_UPDATE);
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_CALC;
            busy_q  <= 1'b1;
          end
        end
        S_CALC: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd_o      = '0;
    cmd_o.clr  = (state_q == S_CLEAR);
    cmd_o.load = (state_q == S_IDLE) && start;
    cmd_o.calc = (state_q == S_CALC);
    cmd_o.rd   = (state_q == S_READ);
    cmd_o.upd  = (state_q == S_UPDATE);
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

/* hdl/cac_datapath.sv */
// ----------------------------------------------------------------------------
// cac_datapath: registers, lane history and count table
// Holds the configuration, the warp key and lane history, computes object
// indexes and performs the saturating read-modify-write of the count table.
// ----------------------------------------------------------------------------
module cac_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cac_pkg::cac_cmd_t             cmd_i,
  output cac_pkg::cac_sts_t             sts_o,
  // Configuration.
  input  logic                          cfg_we_i,
  input  logic [cac_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [cac_pkg::CFG_DW-1:0]    cfg_wdata_i,
  // Input word.
  input  logic                          req_type_i,
  input  logic [cac_pkg::ID_W-1:0]      launch_id_i,
  input  logic [cac_pkg::ID_W-1:0]      block_x_i,
  input  logic [cac_pkg::ID_W-1:0]      block_y_i,
  input  logic [cac_pkg::ID_W-1:0]      block_z_i,
  input  logic [cac_pkg::WARP_W-1:0]    warp_id_i,
  input  logic [cac_pkg::LANE_IN_W-1:0] lane_i,
  input  logic                          region_match_i,
  input  logic [cac_pkg::ADDR_W-1:0]    address_i,
  input  logic [cac_pkg::POS_W-1:0]     row_index_i,
  input  logic [cac_pkg::POS_W-1:0]     col_index_i,
  // Result word.
  output logic [cac_pkg::COUNT_W-1:0]   count_o,
  output logic                          counted_o,
  output logic                          out_of_range_o
);

  // Configuration registers.
  logic [cac_pkg::ID_W-1:0]   target_launch_q;
  logic [cac_pkg::ADDR_W-1:0] region_start_q;
  logic [cac_pkg::OSL2_W-1:0] osl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_launch_q <= '0;
      region_start_q  <= '0;
      osl2_q          <= cac_pkg::OSL2_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        cac_pkg::CFG_TARGET_LAUNCH:    target_launch_q <= cfg_wdata_i[cac_pkg::ID_W-1:0];
        cac_pkg::CFG_REGION_START:     region_start_q  <= cfg_wdata_i;
        cac_pkg::CFG_OBJECT_SIZE_LOG2: osl2_q          <= cfg_wdata_i[cac_pkg::OSL2_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic                          req_type_q;
  logic [cac_pkg::ID_W-1:0]      launch_id_q;
  logic [cac_pkg::ID_W-1:0]      block_x_q;
  logic [cac_pkg::ID_W-1:0]      block_y_q;
  logic [cac_pkg::ID_W-1:0]      block_z_q;
  logic [cac_pkg::WARP_W-1:0]    warp_id_q;
  logic [cac_pkg::LANE_IN_W-1:0] lane_q;
  logic                          region_match_q;
  logic [cac_pkg::ADDR_W-1:0]    address_q;
  logic [cac_pkg::POS_W-1:0]     row_index_q;
  logic [cac_pkg::POS_W-1:0]     col_index_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q     <= req_type_i;
      launch_id_q    <= launch_id_i;
      block_x_q      <= block_x_i;
      block_y_q      <= block_y_i;
      block_z_q      <= block_z_i;
      warp_id_q      <= warp_id_i;
      lane_q         <= lane_i;
      region_match_q <= region_match_i;
      address_q      <= address_i;
      row_index_q    <= row_index_i;
      col_index_q    <= col_index_i;
    end
  end

  // Warp key and lane history.
  logic [cac_pkg::KEY_W-1:0]   last_key_q;
  logic                        key_valid_q;
  logic [cac_pkg::LANES-1:0]   hist_valid_q;
  logic [cac_pkg::LANES-1:0]   hist_valid_d;
  logic [cac_pkg::IDX_W-1:0]   hist_idx_q [cac_pkg::LANES];

  // Index calculation on the captured word.
  logic [cac_pkg::KEY_W-1:0]   key;
  logic                        key_chg;
  logic [cac_pkg::LANE_W-1:0]  li;
  logic                        lane_ok;
  logic                        prev_valid;
  logic [cac_pkg::IDX_W-1:0]   prev_idx;
  logic [cac_pkg::OSL2_W-1:0]  sh;
  logic [cac_pkg::ADDR_W-1:0]  diff;
  logic [cac_pkg::ADDR_W-1:0]  idx_full;
  logic [cac_pkg::IDX_W-1:0]   idx;
  logic                        analysed;
  logic                        addr_nz;
  logic                        nvalid;
  logic                        acc_oor;
  logic                        acc_count;
  logic                        rd_ok;
  logic [cac_pkg::TAB_AW-1:0]  acc_taddr;
  logic [cac_pkg::TAB_AW-1:0]  rd_taddr;

  always_comb begin
    key        = {block_x_q, block_y_q, block_z_q, warp_id_q};
    key_chg    = !key_valid_q || (key != last_key_q);
    li         = cac_pkg::LANE_W'(lane_q);
    lane_ok    = (32'(lane_q) < cac_pkg::LANES);
    prev_valid = hist_valid_q[li] && !key_chg;
    prev_idx   = hist_idx_q[li];
    sh         = (osl2_q > cac_pkg::OSL2_MAX) ? cac_pkg::OSL2_MAX : osl2_q;
    diff       = address_q - region_start_q;
    idx_full   = diff >> sh;
    idx        = idx_full[cac_pkg::IDX_W-1:0];
    analysed   = (launch_id_q == target_launch_q) && region_match_q && lane_ok;
    addr_nz    = (address_q != '0);
    nvalid     = addr_nz && (idx_full < 64'(cac_pkg::OBJECTS));
    acc_oor    = analysed && addr_nz && !nvalid;
    acc_count  = analysed && nvalid && prev_valid;
    rd_ok      = (32'(row_index_q) < cac_pkg::OBJECTS) &&
                 (32'(col_index_q) < cac_pkg::OBJECTS);
    acc_taddr  = cac_pkg::TAB_AW'(prev_idx) * cac_pkg::TAB_AW'(cac_pkg::OBJECTS) +
                 cac_pkg::TAB_AW'(idx);
    rd_taddr   = cac_pkg::TAB_AW'(row_index_q) * cac_pkg::TAB_AW'(cac_pkg::OBJECTS) +
                 cac_pkg::TAB_AW'(col_index_q);
  end

  // Next history valid bits: a new key clears every lane before this lane is set.
  always_comb begin
    hist_valid_d = key_chg ? '0 : hist_valid_q;
    if (analysed) begin
      hist_valid_d[li] = nvalid;
    end
  end

  // Key tracking and history valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q   <= '0;
      key_valid_q  <= 1'b0;
      hist_valid_q <= '0;
    end else if (cmd_i.calc && (req_type_q == cac_pkg::REQ_ACCESS)) begin
      if (key_chg) begin
        last_key_q  <= key;
        key_valid_q <= 1'b1;
      end
      hist_valid_q <= hist_valid_d;
    end
  end

  // History indexes are only read behind their valid bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc && (req_type_q == cac_pkg::REQ_ACCESS) && analysed) begin
      hist_idx_q[li] <= nvalid ? idx : '0;
    end
  end

  // Table access decision for the current word.
  logic [cac_pkg::TAB_AW-1:0] taddr_q;
  logic                       do_count_q;
  logic                       rd_ok_q;
  logic                       oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      do_count_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else if (cmd_i.calc) begin
      if (req_type_q == cac_pkg::REQ_READ) begin
        do_count_q <= 1'b0;
        rd_ok_q    <= rd_ok;
      end else begin
        do_count_q <= acc_count;
        rd_ok_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      taddr_q <= (req_type_q == cac_pkg::REQ_READ) ? rd_taddr : acc_taddr;
      oor_q   <= (req_type_q == cac_pkg::REQ_READ) ? !rd_ok : acc_oor;
    end
  end

  // Clearing pass address.
  logic [cac_pkg::TAB_AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign sts_o.clr_last = (clr_addr_q == cac_pkg::TAB_AW'(cac_pkg::TAB_DEPTH - 1));

  // Count table: one write port shared by clearing and write back.
  logic [cac_pkg::COUNT_W-1:0] tab_mem [cac_pkg::TAB_DEPTH];
  logic [cac_pkg::COUNT_W-1:0] rd_data_q;
  logic [cac_pkg::COUNT_W-1:0] inc;
  logic                        mem_we;
  logic [cac_pkg::TAB_AW-1:0]  mem_waddr;
  logic [cac_pkg::COUNT_W-1:0] mem_wdata;

  // Saturating increment of the stored count.
  assign inc       = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
  assign mem_we    = cmd_i.clr || (cmd_i.upd && do_count_q);
  assign mem_waddr = cmd_i.clr ? clr_addr_q : taddr_q;
  assign mem_wdata = cmd_i.clr ? '0 : inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tab_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rd_data_q <= tab_mem[taddr_q];
    end
  end

  // Result registers.
  logic [cac_pkg::COUNT_W-1:0] count_q;
  logic                        counted_q;
  logic                        res_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      counted_q <= 1'b0;
      res_oor_q <= 1'b0;
    end else if (cmd_i.upd) begin
      if (do_count_q) begin
        count_q <= inc;
      end else if (rd_ok_q) begin
        count_q <= rd_data_q;
      end else begin
        count_q <= '0;
      end
      counted_q <= do_count_q;
      res_oor_q <= oor_q;
    end
  end

  assign count_o        = count_q;
  assign counted_o      = counted_q;
  assign out_of_range_o = res_oor_q;

endmodule

/* hdl/consecutive_access_counter.sv */
// ----------------------------------------------------------------------------
// consecutive_access_counter: lane-to-lane object transition counter
// Counts, per warp lane, transitions between consecutively accessed objects
// of one memory region in a saturating table, and serves count reads.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count table, one entry
// a cycle, with busy high; configuration writes are taken during that time.
// An item is then accepted when start is high and busy is low; it passes
// through index calculation, one read of the count memory and its write back,
// and its result word appears on count_o, counted_o and out_of_range_o with
// done_o high for one cycle. Busy stays high until the result is shown, so a
// new item is taken at the earliest in the cycle that the previous result is
// shown. The result is never held, so the receiver must take it in the cycle
// done_o is high.
module consecutive_access_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          cfg_we_i,
  input  logic [cac_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [cac_pkg::CFG_DW-1:0]    cfg_wdata_i,
  // Command.
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [cac_pkg::ID_W-1:0]      launch_id_i,
  input  logic [cac_pkg::ID_W-1:0]      block_x_i,
  input  logic [cac_pkg::ID_W-1:0]      block_y_i,
  input  logic [cac_pkg::ID_W-1:0]      block_z_i,
  input  logic [cac_pkg::WARP_W-1:0]    warp_id_i,
  input  logic [cac_pkg::LANE_IN_W-1:0] lane_i,
  input  logic                          region_match_i,
  input  logic [cac_pkg::ADDR_W-1:0]    address_i,
  input  logic [cac_pkg::POS_W-1:0]     row_index_i,
  input  logic [cac_pkg::POS_W-1:0]     col_index_i,
  // Result.
  output logic                          done_o,
  output logic [cac_pkg::COUNT_W-1:0]   count_o,
  output logic                          counted_o,
  output logic                          out_of_range_o
);

  cac_pkg::cac_cmd_t cmd;
  cac_pkg::cac_sts_t sts;

  // Sequencer.
  cac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // Registers, history and count table.
  cac_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .launch_id_i    (launch_id_i),
    .block_x_i      (block_x_i),
    .block_y_i      (block_y_i),
    .block_z_i      (block_z_i),
    .warp_id_i      (warp_id_i),
    .lane_i         (lane_i),
    .region_match_i (region_match_i),
    .address_i      (address_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .count_o        (count_o),
    .counted_o      (counted_o),
    .out_of_range_o (out_of_range_o)
  );

  // An accepted word produces its result strobe.
  a_accept_to_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o
  ) else $error("result strobe missing four cycles after accept");

  // A result strobe only follows a cycle in which a word was in progress.
  a_done_after_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)
  ) else $error("result strobe without a word in progress");

  // A counted transition always has an in-range index.
  a_counted_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (done_o && counted_o) |-> !out_of_range_o
  ) else $error("counted transition flagged out of range");

endmodule

/* verif/tb_consecutive_access_counter.sv */
// ----------------------------------------------------------------------------
// tb_consecutive_access_counter: self-checking testbench of the counter
// Drives lane accesses and count reads through the start/busy handshake,
// predicts every result word from a behavioral copy of the lane histories
// and the transition table, and compares each done_o word field by field.
// ----------------------------------------------------------------------------
module tb_consecutive_access_counter;

  // Run control.
  localparam int RESULT_LATENCY  = 4;
  localparam int END_WAIT        = 8;
  localparam int WATCHDOG_LIMIT  = 300000;
  localparam int MAX_REPORTS     = 10;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 88;

  // Warp keys of the directed part: {block_x, block_y, block_z, warp_id}.
  localparam bit [cac_pkg::KEY_W-1:0] KEY_A = {16'd1, 16'd2, 16'd3, 5'd4};
  localparam bit [cac_pkg::KEY_W-1:0] KEY_B = '1;

  // One input word and one result word.
  typedef struct packed {
    bit                          req_type;
    bit [cac_pkg::ID_W-1:0]      launch_id;
    bit [cac_pkg::ID_W-1:0]      block_x;
    bit [cac_pkg::ID_W-1:0]      block_y;
    bit [cac_pkg::ID_W-1:0]      block_z;
    bit [cac_pkg::WARP_W-1:0]    warp_id;
    bit [cac_pkg::LANE_IN_W-1:0] lane;
    bit                          region_match;
    bit [cac_pkg::ADDR_W-1:0]    address;
    bit [cac_pkg::POS_W-1:0]     row_index;
    bit [cac_pkg::POS_W-1:0]     col_index;
  } cac_word_t;

  typedef struct packed {
    bit [cac_pkg::COUNT_W-1:0] count;
    bit                        counted;
    bit                        out_of_range;
  } cac_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_we_i       = 1'b0;
  logic [cac_pkg::CFG_AW-1:0]      cfg_addr_i     = '0;
  logic [cac_pkg::CFG_DW-1:0]      cfg_wdata_i    = '0;
  logic                            start          = 1'b0;
  logic                            req_type_i     = 1'b0;
  logic [cac_pkg::ID_W-1:0]        launch_id_i    = '0;
  logic [cac_pkg::ID_W-1:0]        block_x_i      = '0;
  logic [cac_pkg::ID_W-1:0]        block_y_i      = '0;
  logic [cac_pkg::ID_W-1:0]        block_z_i      = '0;
  logic [cac_pkg::WARP_W-1:0]      warp_id_i      = '0;
  logic [cac_pkg::LANE_IN_W-1:0]   lane_i         = '0;
  logic                            region_match_i = 1'b0;
  logic [cac_pkg::ADDR_W-1:0]      address_i      = '0;
  logic [cac_pkg::POS_W-1:0]       row_index_i    = '0;
  logic [cac_pkg::POS_W-1:0]       col_index_i    = '0;
  logic                            busy;
  logic                            done_o;
  logic [cac_pkg::COUNT_W-1:0]     count_o;
  logic                            counted_o;
  logic                            out_of_range_o;

  // Predicted state of the block and its configuration.
  bit [cac_pkg::COUNT_W-1:0] trans_tab [cac_pkg::TAB_DEPTH];
  bit                        lane_live [cac_pkg::LANES];
  bit [cac_pkg::IDX_W-1:0]   lane_obj  [cac_pkg::LANES];
  bit [cac_pkg::KEY_W-1:0]   warp_key   = '0;
  bit                        key_seen   = 1'b0;
  bit [cac_pkg::ID_W-1:0]    cfg_launch = '0;
  bit [cac_pkg::ADDR_W-1:0]  cfg_base   = '0;
  bit [cac_pkg::OSL2_W-1:0]  cfg_osl2   = cac_pkg::OSL2_RESET;

  // Results awaited from the block, oldest first.
  cac_result_t awaited_counts [$];
  cac_result_t next_expected;

  // Random traffic shaping.
  bit [cac_pkg::KEY_W-1:0] cur_key = '0;
  bit                      no_idle = 1'b0;

  int errors      = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  consecutive_access_counter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .launch_id_i    (launch_id_i),
    .block_x_i      (block_x_i),
    .block_y_i      (block_y_i),
    .block_z_i      (block_z_i),
    .warp_id_i      (warp_id_i),
    .lane_i         (lane_i),
    .region_match_i (region_match_i),
    .address_i      (address_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .done_o         (done_o),
    .count_o        (count_o),
    .counted_o      (counted_o),
    .out_of_range_o (out_of_range_o)
  );

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Predict the result of one accepted word and update the predicted state.
  function automatic cac_result_t count_transition(input cac_word_t w);
    cac_result_t              r;
    bit [cac_pkg::KEY_W-1:0]  key;
    bit [cac_pkg::ADDR_W-1:0] obj;
    bit [cac_pkg::OSL2_W-1:0] sh;
    bit                       obj_ok;
    int                       slot;
    r = '0;
    if (w.req_type == cac_pkg::REQ_READ) begin
      if (w.row_index < cac_pkg::OBJECTS && w.col_index < cac_pkg::OBJECTS) begin
        r.count = trans_tab[int'(w.row_index) * cac_pkg::OBJECTS + int'(w.col_index)];
      end else begin
        r.out_of_range = 1'b1;
      end
      return r;
    end
    // Every lane access compares the warp key, whatever its filters say.
    key = {w.block_x, w.block_y, w.block_z, w.warp_id};
    if (!key_seen || key != warp_key) begin
      warp_key = key;
      key_seen = 1'b1;
      foreach (lane_live[i]) lane_live[i] = 1'b0;
    end
    if (w.launch_id == cfg_launch && w.region_match && w.lane < cac_pkg::LANES) begin
      obj_ok = 1'b0;
      obj    = '0;
      if (w.address != '0) begin
        sh  = (cfg_osl2 > cac_pkg::OSL2_MAX) ? cac_pkg::OSL2_MAX : cfg_osl2;
        obj = (w.address - cfg_base) >> sh;
        if (obj < cac_pkg::OBJECTS) obj_ok = 1'b1;
        else r.out_of_range = 1'b1;
      end
      if (obj_ok && lane_live[w.lane]) begin
        slot = int'(lane_obj[w.lane]) * cac_pkg::OBJECTS + int'(obj);
        if (trans_tab[slot] != '1) trans_tab[slot]++;
        r.count   = trans_tab[slot];
        r.counted = 1'b1;
      end
      lane_live[w.lane] = obj_ok;
      lane_obj[w.lane]  = obj_ok ? obj[cac_pkg::IDX_W-1:0] : '0;
    end
    return r;
  endfunction

  // Word builders; fields the request ignores carry random values.
  function automatic cac_word_t lane_access(input bit [cac_pkg::ID_W-1:0] launch,
                                            input bit [cac_pkg::KEY_W-1:0] key,
                                            input bit [cac_pkg::LANE_IN_W-1:0] lane,
                                            input bit match,
                                            input bit [cac_pkg::ADDR_W-1:0] addr);
    cac_word_t w;
    w.req_type     = cac_pkg::REQ_ACCESS;
    w.launch_id    = launch;
    {w.block_x, w.block_y, w.block_z, w.warp_id} = key;
    w.lane         = lane;
    w.region_match = match;
    w.address      = addr;
    w.row_index    = cac_pkg::POS_W'($urandom);
    w.col_index    = cac_pkg::POS_W'($urandom);
    return w;
  endfunction

  function automatic cac_word_t count_read(input bit [cac_pkg::POS_W-1:0] row,
                                           input bit [cac_pkg::POS_W-1:0] col);
    cac_word_t w;
    w = lane_access(cac_pkg::ID_W'($urandom), cac_pkg::KEY_W'(rand64()),
                    cac_pkg::LANE_IN_W'($urandom), 1'($urandom), rand64());
    w.req_type  = cac_pkg::REQ_READ;
    w.row_index = row;
    w.col_index = col;
    return w;
  endfunction

  // Mostly well-formed warp traffic on a few lanes and objects, some reads,
  // and some noise that breaks keys and filters.
  function automatic cac_word_t random_word();
    cac_word_t                    w;
    int unsigned                  pick;
    bit [cac_pkg::ADDR_W-1:0]     obj;
    bit [cac_pkg::ADDR_W-1:0]     offset;
    bit [cac_pkg::OSL2_W-1:0]     sh;
    bit [cac_pkg::LANE_IN_W-1:0]  lane;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 24) == 0) cur_key = cac_pkg::KEY_W'(rand64());
      sh     = (cfg_osl2 > cac_pkg::OSL2_MAX) ? cac_pkg::OSL2_MAX : cfg_osl2;
      obj    = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 300))
                                           : 64'($urandom_range(0, 7));
      offset = rand64() & ((64'd1 << sh) - 64'd1);
      lane   = ($urandom_range(0, 3) == 0) ? cac_pkg::LANE_IN_W'($urandom_range(0, 31))
                                           : cac_pkg::LANE_IN_W'($urandom_range(0, 3));
      w = lane_access(cfg_launch, cur_key, lane, 1'b1, cfg_base + (obj << sh) + offset);
      if ($urandom_range(0, 19) == 0) w.address = '0;
    end else if (pick < 85) begin
      if ($urandom_range(0, 3) != 0) begin
        w = count_read(cac_pkg::POS_W'($urandom_range(0, 7)),
                       cac_pkg::POS_W'($urandom_range(0, 7)));
      end else begin
        w = count_read(cac_pkg::POS_W'($urandom), cac_pkg::POS_W'($urandom));
      end
    end else if (pick < 93) begin
      // Same warp, but the launch or region filter may reject it.
      w = lane_access($urandom_range(0, 1) ? cfg_launch : cac_pkg::ID_W'($urandom),
                      cur_key, cac_pkg::LANE_IN_W'($urandom_range(0, 3)),
                      1'($urandom), rand64());
    end else begin
      w = lane_access(cac_pkg::ID_W'($urandom), cac_pkg::KEY_W'(rand64()),
                      cac_pkg::LANE_IN_W'($urandom), 1'($urandom), rand64());
    end
    return w;
  endfunction

  // Gap before a word: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void flag_error(input string what, input longint unsigned exp_v,
                                     input longint unsigned act_v);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, what, exp_v, act_v);
    end
  endfunction

  // Present one word and hold it until the block takes it. Start stays high
  // afterwards so that back-to-back words need no second drive in one step.
  task automatic send_word(input cac_word_t w);
    int unsigned gap;
    cac_result_t pred;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= w.req_type;
    launch_id_i    <= w.launch_id;
    block_x_i      <= w.block_x;
    block_y_i      <= w.block_y;
    block_z_i      <= w.block_z;
    warp_id_i      <= w.warp_id;
    lane_i         <= w.lane;
    region_match_i <= w.region_match;
    address_i      <= w.address;
    row_index_i    <= w.row_index;
    col_index_i    <= w.col_index;
    do @(posedge clk_i); while (busy !== 1'b0);
    pred           = count_transition(w);
    awaited_counts = {awaited_counts, pred};
  endtask

  // Drop start and wait until every awaited result has come back.
  task automatic drain();
    start <= 1'b0;
    while (awaited_counts.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cac_pkg::CFG_AW-1:0] idx,
                           input logic [cac_pkg::CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      cac_pkg::CFG_TARGET_LAUNCH:    cfg_launch = data[cac_pkg::ID_W-1:0];
      cac_pkg::CFG_REGION_START:     cfg_base   = data;
      cac_pkg::CFG_OBJECT_SIZE_LOG2: cfg_osl2   = data[cac_pkg::OSL2_W-1:0];
      default: ;
    endcase
  endtask

  // Lane history with reset configuration: first access, two counted
  // transitions, an inactive lane, and a read back of a count.
  task automatic test_lane_history();
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b1, 64'h10));
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b1, 64'h14));
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b1, 64'h12));
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b1, 64'h0));
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b1, 64'h14));
    send_word(count_read(8'd4, 8'd5));
  endtask

  // Launch and region filters keep the history; a new warp key clears it
  // even when the access itself is filtered out.
  task automatic test_filters_and_key();
    send_word(lane_access(16'd1, KEY_A, 5'd0, 1'b1, 64'h18));
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b0, 64'h18));
    send_word(lane_access(16'd0, KEY_A, 5'd0, 1'b1, 64'h18));
    send_word(lane_access(16'hFFFF, KEY_B, 5'd0, 1'b1, 64'h1C));
    send_word(lane_access(16'd0, KEY_B, 5'd0, 1'b1, 64'h1C));
    send_word(lane_access(16'd0, KEY_B, 5'd0, 1'b1, 64'h20));
  endtask

  // Highest object index, the first index past the table, and the corner
  // entries of the table. A count at its maximum cannot be reached by
  // increments within a run of this length.
  task automatic test_index_limits();
    send_word(lane_access(16'd0, KEY_B, 5'd31, 1'b1, 64'h3FC));
    send_word(lane_access(16'd0, KEY_B, 5'd31, 1'b1, 64'h3FC));
    send_word(lane_access(16'd0, KEY_B, 5'd31, 1'b1, 64'h400));
    send_word(lane_access(16'd0, KEY_B, 5'd31, 1'b1, 64'h3FC));
    send_word(count_read(8'd255, 8'd255));
    send_word(count_read(8'd0, 8'd0));
  endtask

  // Extreme register values: region at the top of the address space with
  // byte objects, an address below the region, then the clamped shift.
  task automatic test_extreme_config();
    drain();
    write_reg(cac_pkg::CFG_TARGET_LAUNCH, 64'hFFFF);
    write_reg(cac_pkg::CFG_REGION_START, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(cac_pkg::CFG_OBJECT_SIZE_LOG2, 64'd0);
    send_word(lane_access(16'hFFFF, KEY_B, 5'd31, 1'b1, 64'hFFFF_FFFF_FFFF_FF00));
    send_word(lane_access(16'hFFFF, KEY_B, 5'd31, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(lane_access(16'hFFFF, KEY_B, 5'd31, 1'b1, 64'h1));
    send_word(count_read(8'd0, 8'd255));
    drain();
    write_reg(cac_pkg::CFG_REGION_START, 64'd0);
    write_reg(cac_pkg::CFG_OBJECT_SIZE_LOG2, 64'd7);
    send_word(lane_access(16'hFFFF, KEY_B, 5'd1, 1'b1, 64'hC0));
    send_word(lane_access(16'hFFFF, KEY_B, 5'd1, 1'b1, 64'h13F));
    send_word(count_read(8'd3, 8'd4));
  endtask

  // Random traffic over several register settings, one per object size.
  task automatic test_random_traffic();
    bit [cac_pkg::ID_W-1:0]   launch;
    bit [cac_pkg::ADDR_W-1:0] base;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      case (phase)
        0:       launch = '0;
        1:       launch = '1;
        default: launch = cac_pkg::ID_W'($urandom);
      endcase
      case (phase)
        2:       base = '0;
        3:       base = 64'hFFFF_FFFF_FFFF_FFC0;
        default: base = rand64();
      endcase
      // Bits above the launch and object size widths are written too and must be dropped.
      write_reg(cac_pkg::CFG_TARGET_LAUNCH, (rand64() << cac_pkg::ID_W) | 64'(launch));
      write_reg(cac_pkg::CFG_REGION_START, base);
      write_reg(cac_pkg::CFG_OBJECT_SIZE_LOG2,
                (rand64() << cac_pkg::OSL2_W) | 64'(cac_pkg::OSL2_W'(phase)));
      no_idle = (phase % 3 == 1);
      cur_key = cac_pkg::KEY_W'(rand64());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_word(random_word());
    end
    no_idle = 1'b0;
  endtask

  // Compare every result word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_counts.size() == 0) begin
        flag_error("unexpected result, count", 64'd0, 64'(count_o));
      end else begin
        next_expected = awaited_counts.pop_front();
        if (count_o !== next_expected.count) begin
          flag_error("count", 64'(next_expected.count), 64'(count_o));
        end
        if (counted_o !== next_expected.counted) begin
          flag_error("counted", 64'(next_expected.counted), 64'(counted_o));
        end
        if (out_of_range_o !== next_expected.out_of_range) begin
          flag_error("out_of_range", 64'(next_expected.out_of_range),
                     64'(out_of_range_o));
        end
      end
    end
  end

  // Stop a hung run; the clearing pass after reset fits well inside the limit.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_lane_history();
    test_filters_and_key();
    test_index_limits();
    test_extreme_config();
    test_random_traffic();
    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
